@@ design/lobm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and codes
// Command, status and result codes plus the controller/datapath structs.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;
  localparam logic [1:0] CMD_MATCH  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_DUP       = 2'd3;

  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input transaction
    logic scan_start; // clear the scan accumulators
    logic scan_step;  // examine one slot
    logic do_fill;    // apply a fill to the best slot and emit it
    logic do_final;   // finish the command and emit the completion
  } lobm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic remaining_zero;
    logic out_busy;
    logic free_busy;
  } lobm_stat_t;

endpackage

`default_nettype wire

@@ design/lobm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_ctrl: command sequencer
// Steps each command through a slot scan, then fills or completion.
// ----------------------------------------------------------------------------
module lobm_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          cmd,
  input  wire  lobm_pkg::lobm_stat_t stat,
  output lobm_pkg::lobm_cmd_t ctl
);
  import lobm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] op;

  // Sequencer state and captured opcode.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= CMD_ADD;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) op <= cmd;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !stat.free_busy;
        if (in_valid && !stat.free_busy) begin
          ctl.load       = 1'b1;
          ctl.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        // The scan compares age ranks, so it holds until compaction has settled them.
        ctl.scan_step = !stat.free_busy;
        if (stat.scan_done) state_next = S_ACT;
      end
      S_ACT: begin
        if (!stat.out_busy && !stat.free_busy) begin
          if (op == CMD_MATCH && stat.best_found && !stat.remaining_zero) begin
            ctl.do_fill    = 1'b1;
            ctl.scan_start = 1'b1;
            state_next     = S_SCAN;
          end else begin
            ctl.do_final = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ design/lobm_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_dp: slot pool datapath
// Slot store, one-slot-per-cycle scan while no compaction runs, rank maintenance and output register.
// ----------------------------------------------------------------------------
module lobm_dp #(
  parameter int ORDER_SLOTS  = 32,
  parameter int PRICE_LEVELS = 1024
) (
  input  wire         clk,
  input  wire         rst,
  input  wire  [1:0]  cmd,
  input  wire  [31:0] order_id,
  input  wire         side,
  input  wire  [9:0]  price,
  input  wire  [31:0] quantity,
  input  wire  lobm_pkg::lobm_cmd_t ctl,
  output lobm_pkg::lobm_stat_t stat,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        kind,
  output logic [1:0]  status,
  output logic [31:0] resting_id,
  output logic [9:0]  fill_price,
  output logic [31:0] amount,
  output logic        last
);
  import lobm_pkg::*;

  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW = $clog2(ORDER_SLOTS + 1);
  localparam logic [9:0] PMAX = (PRICE_LEVELS >= 1024) ? 10'h3FF : 10'(PRICE_LEVELS - 1);

  // Slot store.
  logic [ORDER_SLOTS-1:0] slot_valid;
  logic [31:0] slot_order_id [ORDER_SLOTS];
  logic        slot_side     [ORDER_SLOTS];
  logic [9:0]  slot_price    [ORDER_SLOTS];
  logic [31:0] slot_quantity [ORDER_SLOTS];
  logic [IW-1:0] slot_age_rank [ORDER_SLOTS];

  // Captured command.
  logic [1:0]  r_cmd;
  logic [31:0] r_id;
  logic        r_side;
  logic [9:0]  r_price;
  logic [31:0] remaining;
  logic [31:0] r_qty;

  // Scan accumulators.
  logic [CW-1:0] scan_idx;
  logic          found_id;
  logic [IW-1:0] id_slot;
  logic          have_best;
  logic [IW-1:0] best;
  logic          have_free;
  logic [IW-1:0] free_idx;
  logic [CW-1:0] count;

  // Rank compaction pass after a slot is freed.
  logic          free_busy;
  logic [IW-1:0] free_rank;
  logic [CW-1:0] free_idx_cnt;

  logic [IW-1:0] si;
  logic          elig;
  logic          better;
  logic [31:0]   fill_amt;
  logic [31:0]   best_q;

  assign si = scan_idx[IW-1:0];

  // Eligibility and priority of the slot under scan.
  always_comb begin
    elig = slot_valid[si] && (slot_side[si] != r_side) &&
           (r_side ? (slot_price[si] >= r_price) : (slot_price[si] <= r_price));
    if (!have_best) better = 1'b1;
    else if (slot_price[si] == slot_price[best])
      better = slot_age_rank[si] < slot_age_rank[best];
    else if (!r_side) better = slot_price[si] < slot_price[best];
    else better = slot_price[si] > slot_price[best];
    best_q   = slot_quantity[best];
    fill_amt = (best_q < remaining) ? best_q : remaining;
  end

  // A match whose id already rests never fills.
  assign stat.scan_done      = ctl.scan_step && (scan_idx == CW'(ORDER_SLOTS - 1));
  assign stat.best_found     = have_best && !found_id;
  assign stat.remaining_zero = (remaining == 32'd0);
  assign stat.out_busy       = out_valid;
  assign stat.free_busy      = free_busy;

  // Control registers: valid bits, scan, compaction, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      free_busy  <= 1'b0;
      out_valid  <= 1'b0;
      scan_idx   <= '0;
      have_best  <= 1'b0;
      found_id   <= 1'b0;
      have_free  <= 1'b0;
      count      <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctl.scan_start) begin
        scan_idx  <= '0;
        have_best <= 1'b0;
        found_id  <= 1'b0;
        have_free <= 1'b0;
        count     <= '0;
      end else if (ctl.scan_step) begin
        scan_idx <= scan_idx + CW'(1);
        if (slot_valid[si]) count <= count + CW'(1);
        else if (!have_free) have_free <= 1'b1;
        if (slot_valid[si] && slot_order_id[si] == r_id) found_id <= 1'b1;
        if (elig && better) have_best <= 1'b1;
      end
      // Rank compaction, one slot per cycle.
      if (free_busy) begin
        if (free_idx_cnt == CW'(ORDER_SLOTS - 1)) free_busy <= 1'b0;
      end
      if (ctl.do_fill) begin
        out_valid <= 1'b1;
        if (best_q == fill_amt) begin
          slot_valid[best] <= 1'b0;
          free_busy        <= 1'b1;
        end
      end
      if (ctl.do_final) begin
        out_valid <= 1'b1;
        unique case (r_cmd)
          CMD_ADD: begin
            if (!found_id && r_qty != 32'd0 && have_free) slot_valid[free_idx] <= 1'b1;
          end
          CMD_CANCEL: begin
            if (found_id) begin
              slot_valid[id_slot] <= 1'b0;
              free_busy           <= 1'b1;
            end
          end
          CMD_MODIFY: begin
            if (found_id && r_qty == 32'd0) begin
              slot_valid[id_slot] <= 1'b0;
              free_busy           <= 1'b1;
            end
          end
          CMD_MATCH: begin
            if (!found_id && remaining != 32'd0 && have_free)
              slot_valid[free_idx] <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers: captured command, scan results, slot fields, outputs.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r_cmd     <= cmd;
      r_id      <= order_id;
      r_side    <= side;
      r_price   <= (price > PMAX) ? PMAX : price;
      r_qty     <= quantity;
      remaining <= quantity;
    end
    if (ctl.scan_step) begin
      if (slot_valid[si] && slot_order_id[si] == r_id) id_slot <= si;
      if (!slot_valid[si] && !have_free) free_idx <= si;
      if (elig && better) best <= si;
    end
    if (free_busy) begin
      free_idx_cnt <= free_idx_cnt + CW'(1);
      if (slot_valid[free_idx_cnt[IW-1:0]] &&
          slot_age_rank[free_idx_cnt[IW-1:0]] > free_rank)
        slot_age_rank[free_idx_cnt[IW-1:0]] <= slot_age_rank[free_idx_cnt[IW-1:0]] - IW'(1);
    end
    if (ctl.do_fill) begin
      kind       <= KIND_FILL;
      status     <= ST_OK;
      resting_id <= slot_order_id[best];
      fill_price <= slot_price[best];
      amount     <= fill_amt;
      last       <= 1'b0;
      remaining  <= remaining - fill_amt;
      slot_quantity[best] <= best_q - fill_amt;
      free_rank    <= slot_age_rank[best];
      free_idx_cnt <= '0;
    end
    if (ctl.do_final) begin
      kind       <= KIND_DONE;
      resting_id <= r_id;
      fill_price <= 10'd0;
      last       <= 1'b1;
      status     <= ST_OK;
      amount     <= 32'd0;
      free_rank    <= slot_age_rank[id_slot];
      free_idx_cnt <= '0;
      unique case (r_cmd)
        CMD_ADD: begin
          if (found_id) status <= ST_DUP;
          else if (r_qty != 32'd0) begin
            if (have_free) begin
              amount <= r_qty;
              slot_order_id[free_idx] <= r_id;
              slot_side[free_idx]     <= r_side;
              slot_price[free_idx]    <= r_price;
              slot_quantity[free_idx] <= r_qty;
              slot_age_rank[free_idx] <= count[IW-1:0];
            end else status <= ST_FULL;
          end
        end
        CMD_CANCEL: if (!found_id) status <= ST_NOT_FOUND;
        CMD_MODIFY: begin
          if (!found_id) status <= ST_NOT_FOUND;
          else if (r_qty != 32'd0) begin
            amount <= r_qty;
            slot_quantity[id_slot] <= r_qty;
          end
        end
        CMD_MATCH: begin
          if (found_id) status <= ST_DUP;
          else if (remaining != 32'd0) begin
            amount <= remaining;
            if (have_free) begin
              slot_order_id[free_idx] <= r_id;
              slot_side[free_idx]     <= r_side;
              slot_price[free_idx]    <= r_price;
              slot_quantity[free_idx] <= remaining;
              slot_age_rank[free_idx] <= count[IW-1:0];
            end else status <= ST_FULL;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/limit_order_book_matcher_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top: price-time priority limit order book
// Add, cancel, modify and match commands over a fixed pool of order slots.
// ----------------------------------------------------------------------------
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | cmd, order_id, side, price, quantity
// out     | out_valid / out_ready| kind, status, resting_id, fill_price, amount, last
//
// A command is taken, then each pass over the pool examines one slot a
// cycle, held while compaction runs, and ends in an act: a fill starts
// another pass, else the completion. Freeing a slot starts a rank
// compaction pass; the next scan or the next transaction waits for it.
// Reset clears valid bits and control state, not slot contents. The output
// register holds each result until taken; a stalled output halts the sequencer.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_top #(
  parameter int ORDER_SLOTS  = 32,
  parameter int PRICE_LEVELS = 1024
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  cmd,
  input  wire  [31:0] order_id,
  input  wire         side,
  input  wire  [9:0]  price,
  input  wire  [31:0] quantity,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        kind,
  output logic [1:0]  status,
  output logic [31:0] resting_id,
  output logic [9:0]  fill_price,
  output logic [31:0] amount,
  output logic        last
);
  import lobm_pkg::*;

  lobm_cmd_t  ctl;
  lobm_stat_t stat;

  // Sequencer.
  lobm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .stat(stat), .ctl(ctl)
  );

  // Slot pool and result register.
  lobm_dp #(.ORDER_SLOTS(ORDER_SLOTS), .PRICE_LEVELS(PRICE_LEVELS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .order_id(order_id), .side(side),
    .price(price), .quantity(quantity), .ctl(ctl), .stat(stat),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .status(status),
    .resting_id(resting_id), .fill_price(fill_price), .amount(amount), .last(last)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the limit order book matcher
// Commands go in through a valid/ready sender and every result is compared
// against a price-time priority book model held inside the bench.
// ----------------------------------------------------------------------------
module tb;
  import lobm_pkg::*;

  localparam int SLOTS = 32;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [31:0] resting_id;
    logic [9:0]  fill_price;
    logic [31:0] amount;
    logic        last;
  } book_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [31:0] order_id;
  logic        side;
  logic [9:0]  price;
  logic [31:0] quantity;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic [1:0]  status;
  logic [31:0] resting_id;
  logic [9:0]  fill_price;
  logic [31:0] amount;
  logic        last;

  // Model of the book: one entry per slot.
  logic        bk_valid [SLOTS];
  logic [31:0] bk_id    [SLOTS];
  logic        bk_side  [SLOTS];
  logic [9:0]  bk_price [SLOTS];
  logic [31:0] bk_qty   [SLOTS];
  int          bk_rank  [SLOTS];

  book_result_t expected_reports[$];
  int           errors;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           holdoff_cycles;
  logic [31:0]  fresh_id;

  limit_order_book_matcher_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .order_id   (order_id),
    .side       (side),
    .price      (price),
    .quantity   (quantity),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .status     (status),
    .resting_id (resting_id),
    .fill_price (fill_price),
    .amount     (amount),
    .last       (last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic int find_order(input logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  task automatic release_slot(input int s);
    int r;
    r = bk_rank[s];
    bk_valid[s] = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (bk_valid[i] && bk_rank[i] > r) bk_rank[i]--;
  endtask

  task automatic rest_order(input logic [31:0] id, input logic sd, input logic [9:0] p,
                            input logic [31:0] q, output bit stored);
    int s;
    int count;
    s = -1;
    count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (bk_valid[i]) count++;
      else if (s < 0) s = i;
    end
    stored = (s >= 0);
    if (stored) begin
      bk_valid[s] = 1'b1;
      bk_id[s]    = id;
      bk_side[s]  = sd;
      bk_price[s] = p;
      bk_qty[s]   = q;
      bk_rank[s]  = count;
    end
  endtask

  task automatic push_report(input logic k, input logic [1:0] st, input logic [31:0] id,
                             input logic [9:0] p, input logic [31:0] amt);
    book_result_t r;
    r.kind       = k;
    r.status     = st;
    r.resting_id = id;
    r.fill_price = p;
    r.amount     = amt;
    r.last       = k;
    expected_reports.push_back(r);
  endtask

  // Works out every report that one accepted command produces.
  task automatic predict_book(input logic [1:0] c, input logic [31:0] id, input logic sd,
                              input logic [9:0] p, input logic [31:0] q);
    int s;
    int best;
    bit stored;
    bit better;
    logic [31:0] rem;
    logic [31:0] f;
    s = find_order(id);
    case (c)
      CMD_ADD: begin
        if (s >= 0) push_report(KIND_DONE, ST_DUP, id, 10'd0, 32'd0);
        else if (q == 0) push_report(KIND_DONE, ST_OK, id, 10'd0, 32'd0);
        else begin
          rest_order(id, sd, p, q, stored);
          if (stored) push_report(KIND_DONE, ST_OK, id, 10'd0, q);
          else push_report(KIND_DONE, ST_FULL, id, 10'd0, 32'd0);
        end
      end
      CMD_CANCEL: begin
        if (s < 0) push_report(KIND_DONE, ST_NOT_FOUND, id, 10'd0, 32'd0);
        else begin
          release_slot(s);
          push_report(KIND_DONE, ST_OK, id, 10'd0, 32'd0);
        end
      end
      CMD_MODIFY: begin
        if (s < 0) push_report(KIND_DONE, ST_NOT_FOUND, id, 10'd0, 32'd0);
        else if (q == 0) begin
          release_slot(s);
          push_report(KIND_DONE, ST_OK, id, 10'd0, 32'd0);
        end else begin
          bk_qty[s] = q;
          push_report(KIND_DONE, ST_OK, id, 10'd0, q);
        end
      end
      default: begin
        if (s >= 0) push_report(KIND_DONE, ST_DUP, id, 10'd0, 32'd0);
        else begin
          rem = q;
          while (rem != 0) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (!bk_valid[i] || bk_side[i] == sd) continue;
              if (sd == 1'b0 ? (bk_price[i] > p) : (bk_price[i] < p)) continue;
              if (best < 0) begin
                best = i;
                continue;
              end
              if (bk_price[i] == bk_price[best]) better = bk_rank[i] < bk_rank[best];
              else better = (sd == 1'b0) ? (bk_price[i] < bk_price[best])
                                         : (bk_price[i] > bk_price[best]);
              if (better) best = i;
            end
            if (best < 0) break;
            f = (bk_qty[best] < rem) ? bk_qty[best] : rem;
            push_report(KIND_FILL, ST_OK, bk_id[best], bk_price[best], f);
            rem = rem - f;
            bk_qty[best] = bk_qty[best] - f;
            if (bk_qty[best] == 0) release_slot(best);
          end
          if (rem == 0) push_report(KIND_DONE, ST_OK, id, 10'd0, 32'd0);
          else begin
            rest_order(id, sd, p, rem, stored);
            push_report(KIND_DONE, stored ? ST_OK : ST_FULL, id, 10'd0, rem);
          end
        end
      end
    endcase
  endtask

  // ------------------------------------------------------------- sending

  // Offers one command and holds it until the transaction is accepted.
  task automatic send_command(input logic [1:0] c, input logic [31:0] id, input logic sd,
                              input logic [9:0] p, input logic [31:0] q);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    order_id <= id;
    side     <= sd;
    price    <= p;
    quantity <= q;
    do @(posedge clk); while (!in_ready);
    predict_book(c, id, sd, p, q);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Picks an id that is resting most of the time, otherwise a small or wide one.
  function automatic logic [31:0] pick_id();
    logic [31:0] live[$];
    for (int i = 0; i < SLOTS; i++)
      if (bk_valid[i]) live.push_back(bk_id[i]);
    if (live.size() != 0 && $urandom_range(9) < 6) return live[$urandom_range(live.size() - 1)];
    if ($urandom_range(9) < 8) return $urandom_range(1, 48);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_qty();
    if ($urandom_range(9) == 0) return $urandom;
    if ($urandom_range(19) == 0) return 32'd0;
    return $urandom_range(1, 100);
  endfunction

  function automatic logic [9:0] pick_price();
    if ($urandom_range(9) == 0) return 10'($urandom);
    return 10'($urandom_range(494, 506));
  endfunction

  // --------------------------------------------------------------- tests

  task automatic test_directed;
    send_command(CMD_ADD, 32'h0, 1'b1, 10'd0, 32'hFFFF_FFFF);
    send_command(CMD_ADD, 32'hFFFF_FFFF, 1'b0, 10'd1023, 32'd5);
    send_command(CMD_ADD, 32'h0, 1'b0, 10'd7, 32'd3);              // duplicate id
    send_command(CMD_ADD, 32'd9, 1'b0, 10'd7, 32'd0);              // zero quantity
    send_command(CMD_ADD, 32'd10, 1'b1, 10'd500, 32'd4);           // crosses, rests
    send_command(CMD_ADD, 32'd11, 1'b1, 10'd400, 32'd6);
    send_command(CMD_ADD, 32'd12, 1'b1, 10'd400, 32'd2);
    send_command(CMD_CANCEL, 32'd77, 1'b0, 10'd0, 32'd0);          // unknown id
    send_command(CMD_MODIFY, 32'd78, 1'b0, 10'd0, 32'd5);          // unknown id
    send_command(CMD_MODIFY, 32'd11, 1'b0, 10'd0, 32'd8);
    send_command(CMD_MATCH, 32'd10, 1'b0, 10'd600, 32'd1);         // duplicate id
    send_command(CMD_MATCH, 32'd20, 1'b0, 10'd600, 32'd0);         // zero quantity
    send_command(CMD_MATCH, 32'd21, 1'b0, 10'd450, 32'd9);         // filled in full
    send_command(CMD_MATCH, 32'd22, 1'b0, 10'd1023, 32'd2);        // fully filled
    send_command(CMD_MATCH, 32'd23, 1'b1, 10'd0, 32'd3);           // sell side
    send_command(CMD_MATCH, 32'd24, 1'b0, 10'd0, 32'd3);           // crosses at price 0
    send_command(CMD_MODIFY, 32'd24, 1'b0, 10'd0, 32'd0);          // modify to zero
    send_command(CMD_CANCEL, 32'h0, 1'b0, 10'd0, 32'd0);
    send_command(CMD_CANCEL, 32'hFFFF_FFFF, 1'b0, 10'd0, 32'd0);
    send_command(CMD_CANCEL, 32'd12, 1'b0, 10'd0, 32'd0);
    send_command(CMD_CANCEL, 32'd21, 1'b0, 10'd0, 32'd0);
    send_command(CMD_CANCEL, 32'd10, 1'b0, 10'd0, 32'd0);
    wait_drained();
  endtask

  // Fills the pool, then runs into a full pool and a sweep of every slot.
  task automatic test_pool_full;
    for (int i = 0; i < SLOTS; i++)
      send_command(CMD_ADD, 32'd100 + i, 1'b0, 10'd300 + i[4:0], 32'd1);
    send_command(CMD_ADD, 32'd200, 1'b0, 10'd300, 32'd1);
    send_command(CMD_MATCH, 32'd201, 1'b0, 10'd900, 32'd7);
    send_command(CMD_MATCH, 32'd202, 1'b1, 10'd0, 32'd40);
    send_command(CMD_CANCEL, 32'd202, 1'b0, 10'd0, 32'd0);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [1:0] c;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      c = (r < 35) ? CMD_ADD : (r < 70) ? CMD_MATCH : (r < 85) ? CMD_CANCEL : CMD_MODIFY;
      if ((c == CMD_ADD || c == CMD_MATCH) && $urandom_range(9) < 8) begin
        fresh_id = fresh_id + 1;
        send_command(c, fresh_id, 1'($urandom_range(1)), pick_price(), pick_qty());
      end else
        send_command(c, pick_id(), 1'($urandom_range(1)), pick_price(), pick_qty());
    end
  endtask

  // The receiver stops for a long stretch while commands keep coming.
  task automatic test_output_stall;
    holdoff_cycles = 600;
    test_random(12);
    wait_drained();
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = CMD_ADD;
    order_id       = '0;
    side           = 1'b0;
    price          = '0;
    quantity       = '0;
    errors         = 0;
    send_idle_pct  = 8;
    recv_idle_pct  = 52;
    holdoff_cycles = 0;
    fresh_id       = 32'd1000;
    for (int i = 0; i < SLOTS; i++) bk_valid[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_pool_full();
    test_random(50);
    send_idle_pct = 52;
    recv_idle_pct = 8;
    test_random(50);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(50);
    test_output_stall();

    wait_drained();
    repeat (1200) @(posedge clk);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver readiness, with an optional long hold-off.
  always @(posedge clk) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial out_ready = 1'b0;

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compares each output transaction with the oldest expected report.
  always @(posedge clk) begin
    book_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report id %0h", resting_id);
        errors++;
      end else begin
        e = expected_reports.pop_front();
        check_field("kind", 32'(e.kind), 32'(kind));
        check_field("status", 32'(e.status), 32'(status));
        check_field("resting_id", e.resting_id, resting_id);
        check_field("fill_price", 32'(e.fill_price), 32'(fill_price));
        check_field("amount", e.amount, amount);
        check_field("last", 32'(e.last), 32'(last));
      end
    end
  end

endmodule
